>>> rtl/ptic_pkg.sv
// Shared types and constants of the pair and triple index codec.
package ptic_pkg;

	localparam int VERTEX_W = 8;
	localparam int COUNT_W = 9;
	localparam int INDEX_W = 23;
	localparam int VAL_W = 26;
	localparam int BLOCK_W = 17;
	localparam int QUOT_W = 9;
	localparam int DIV_CNT_W = 4;
	localparam int MAX_VERTICES_DEF = 256;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
	localparam logic [DIV_CNT_W-1:0] DIV_TOP = 4'(QUOT_W - 1);

	typedef enum logic [1:0] {
		OP_RANK_PAIR = 2'd0,
		OP_UNRANK_PAIR = 2'd1,
		OP_RANK_TRIPLE = 2'd2,
		OP_UNRANK_TRIPLE = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic init;
		logic div_step;
		logic walk_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic is_div;
		logic div_last;
		logic walk_more;
	} status_t;

endpackage

>>> rtl/ptic_datapath.sv
// Datapath of the codec: operand capture, shared multiplier, divider and row walker.
module ptic_datapath import ptic_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic [COUNT_W-1:0]  vertex_count,
	input  cmd_t                cmd,
	input  op_t                 in_op,
	input  logic [VERTEX_W-1:0] in_a,
	input  logic [VERTEX_W-1:0] in_b,
	input  logic [VERTEX_W-1:0] in_c,
	input  logic [INDEX_W-1:0]  in_idx,
	output status_t             sts,
	output logic [INDEX_W-1:0]  res_index,
	output logic [VERTEX_W-1:0] res_low,
	output logic [VERTEX_W-1:0] res_high,
	output logic [VERTEX_W-1:0] res_third,
	output logic                res_err
);

	localparam logic [COUNT_W+1:0] MaxV = (COUNT_W+2)'(MAX_VERTICES);

	op_t                 op_q;
	logic [VERTEX_W-1:0] c_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [COUNT_W-1:0]  lo_q, hi_q, m_q, r_q;
	logic                verr_q, err_q;
	logic [VAL_W-1:0]    prod_q, limit_q, val_q;
	logic [BLOCK_W-1:0]  block_q;
	logic [QUOT_W-1:0]   q_q;
	logic [DIV_CNT_W-1:0] dcnt_q;

	logic                triple_in, unrank_in, verr;
	logic [VERTEX_W-1:0] a2, b2;
	logic [COUNT_W-1:0]  mul_x;
	logic [BLOCK_W-1:0]  mul_y;
	logic [VAL_W-1:0]    mul_p;
	logic [VAL_W-1:0]    dshift;
	logic                ge;
	logic [COUNT_W-1:0]  row_len;
	logic [COUNT_W-1:0]  hi_un, lo_fix, hi_fix;
	logic [COUNT_W:0]    r_next;

	assign triple_in = in_op[1];
	assign unrank_in = in_op[0];

	// In a triple the pair is ranked with the third vertex removed.
	always_comb begin
		a2 = (triple_in && in_a > in_c) ? in_a - 8'd1 : in_a;
		b2 = (triple_in && in_b > in_c) ? in_b - 8'd1 : in_b;
		verr = (vertex_count < 9'd3) || ({2'b00, vertex_count} > MaxV);
		if (!unrank_in) begin
			if (in_a == in_b || {1'b0, in_a} >= vertex_count
				|| {1'b0, in_b} >= vertex_count)
				verr = 1'b1;
		end
		if (in_op == OP_RANK_TRIPLE) begin
			if (in_a == in_c || in_b == in_c || {1'b0, in_c} >= vertex_count)
				verr = 1'b1;
		end
	end

	// One multiplier, its operands chosen by the step in progress.
	always_comb begin
		mul_x = vertex_count;
		mul_y = BLOCK_W'(vertex_count - 9'd1);
		if (cmd.mul_a) begin
			if (op_q[1]) begin
				mul_x = vertex_count - 9'd1;
				mul_y = BLOCK_W'(vertex_count - 9'd2);
			end
		end else if (cmd.mul_b) begin
			mul_y = prod_q[BLOCK_W:1];
		end else begin
			mul_x = {1'b0, c_q};
			mul_y = block_q;
		end
		mul_p = VAL_W'(mul_x) * VAL_W'(mul_y);
	end

	assign dshift = VAL_W'(block_q) << dcnt_q;
	assign ge = val_q >= dshift;
	assign row_len = m_q - 9'd1 - r_q;
	assign r_next = {1'b0, r_q} + 10'd1;

	always_comb begin
		sts.err = err_q;
		sts.is_div = (op_q == OP_UNRANK_TRIPLE);
		sts.div_last = (dcnt_q == '0);
		if (op_q[0])
			sts.walk_more = (r_next < {1'b0, m_q}) && (val_q >= VAL_W'(row_len));
		else
			sts.walk_more = r_q < lo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			c_q <= in_c;
			idx_q <= in_idx;
			verr_q <= verr;
			m_q <= triple_in ? vertex_count - 9'd1 : vertex_count;
			lo_q <= {1'b0, (a2 < b2) ? a2 : b2};
			hi_q <= {1'b0, (a2 < b2) ? b2 : a2};
		end
		if (cmd.mul_a)
			prod_q <= mul_p;
		if (cmd.mul_b) begin
			block_q <= prod_q[BLOCK_W:1];
			limit_q <= op_q[1] ? mul_p : VAL_W'(prod_q[BLOCK_W:1]);
		end
		if (cmd.init) begin
			err_q <= verr_q || (op_q[0] && VAL_W'(idx_q) >= limit_q);
			r_q <= '0;
			q_q <= '0;
			dcnt_q <= DIV_TOP;
			unique case (op_q)
				OP_RANK_PAIR: val_q <= '0;
				OP_RANK_TRIPLE: val_q <= mul_p;
				OP_UNRANK_PAIR, OP_UNRANK_TRIPLE: val_q <= VAL_W'(idx_q);
				default: val_q <= '0;
			endcase
		end
		if (cmd.div_step) begin
			if (ge)
				val_q <= val_q - dshift;
			q_q <= {q_q[QUOT_W-2:0], ge};
			dcnt_q <= dcnt_q - 4'd1;
		end
		if (cmd.walk_step) begin
			if (op_q[0])
				val_q <= val_q - VAL_W'(row_len);
			else
				val_q <= val_q + VAL_W'(row_len);
			r_q <= r_next[COUNT_W-1:0];
		end
	end

	// Pair vertices at or above the third vertex move up by one.
	always_comb begin
		hi_un = val_q[COUNT_W-1:0] + r_q + 9'd1;
		lo_fix = r_q;
		hi_fix = hi_un;
		if (op_q == OP_UNRANK_TRIPLE) begin
			if (r_q >= q_q)
				lo_fix = r_q + 9'd1;
			if (hi_un >= q_q)
				hi_fix = hi_un + 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_err <= err_q;
			res_index <= '0;
			res_low <= '0;
			res_high <= '0;
			res_third <= '0;
			if (!err_q) begin
				if (!op_q[0]) begin
					res_index <= INDEX_W'(val_q + VAL_W'(hi_q - lo_q - 9'd1));
				end else begin
					res_low <= lo_fix[VERTEX_W-1:0];
					res_high <= hi_fix[VERTEX_W-1:0];
					if (op_q[1])
						res_third <= q_q[VERTEX_W-1:0];
				end
			end
		end
	end

endmodule

>>> rtl/ptic_ctrl.sv
// Controller of the codec: sequences one request and owns the handshakes.
module ptic_ctrl import ptic_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MUL_A = 7'b0000010,
		S_MUL_B = 7'b0000100,
		S_INIT  = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_WALK  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_MUL_A;
				end
			end
			S_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d = S_MUL_B;
			end
			S_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (!sts.err && sts.is_div) begin
					cmd.div_step = 1'b1;
					if (sts.div_last)
						state_d = S_WALK;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (!sts.err && sts.walk_more)
					cmd.walk_step = 1'b1;
				else
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/pair_triple_index_codec_unit.sv
// Top level of the pair and triple index codec.
//
//  channel  | signals                                  | contents
//  ---------+------------------------------------------+-------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata/tuser         | one rank or unrank request
//  m_axis   | m_axis_tvalid/tready/tdata/tuser         | index or recovered vertices
//  cfg      | cfg_valid/cfg_ready/cfg_data             | vertex count register
//
// A request is captured, then runs two multiply steps, an init step, the divider (only
// for a triple unrank, whose divider runs 9 steps) and a walk of one triangular row per
// step; the next request is taken in the cycle after the result is registered.
// Reset puts the controller in idle, clears the output valid and sets the vertex
// count to 256. A stalled result sits in the output register while the next request
// is taken; it walks and then waits in the done state only while that result is not taken.
module pair_triple_index_codec_unit import ptic_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// first_vertex[7:0], second_vertex[15:8], third_vertex[23:16], index_in[46:24]
	input  logic [47:0]        s_axis_tdata,
	// op[1:0]
	input  logic [1:0]         s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// index_out[22:0], vertex_low[30:23], vertex_high[38:31], vertex_third[46:39]
	output logic [47:0]        m_axis_tdata,
	// error[0]
	output logic               m_axis_tuser,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	logic [COUNT_W-1:0]  vertex_count_q;
	cmd_t                cmd;
	status_t             sts;
	logic [INDEX_W-1:0]  res_index;
	logic [VERTEX_W-1:0] res_low, res_high, res_third;
	logic                res_err;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vertex_count_q <= COUNT_RESET;
		else if (cfg_valid)
			vertex_count_q <= cfg_data;
	end

	ptic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptic_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk          (clk),
		.vertex_count (vertex_count_q),
		.cmd          (cmd),
		.in_op        (op_t'(s_axis_tuser)),
		.in_a         (s_axis_tdata[7:0]),
		.in_b         (s_axis_tdata[15:8]),
		.in_c         (s_axis_tdata[23:16]),
		.in_idx       (s_axis_tdata[46:24]),
		.sts          (sts),
		.res_index    (res_index),
		.res_low      (res_low),
		.res_high     (res_high),
		.res_third    (res_third),
		.res_err      (res_err)
	);

	assign m_axis_tdata = {1'b0, res_third, res_high, res_low, res_index};
	assign m_axis_tuser = res_err;

endmodule
